@@ rtl/core/aos_pkg.sv @@
package aos_pkg;

    localparam int HEADER_LEN  = 8;
    localparam int PAYLOAD_LEN = 384;
    localparam int MEAN_SHIFT  = 4;

    localparam int PACKET_TOTAL      = HEADER_LEN + PAYLOAD_LEN;
    localparam int FULL_TRIPLE_BYTES = (PAYLOAD_LEN / 3) * 3;
    localparam int POS_W             = $clog2(PACKET_TOTAL);
    localparam int HDR_IDX_W         = $clog2(HEADER_LEN);

    localparam int SAMPLE_W = 12;
    localparam int MEAN_W   = 16;
    localparam int THR_W    = 12;

    localparam logic [7:0]          SYNC_FIRST  = 8'hA5;
    localparam logic [7:0]          SYNC_SECOND = 8'h5A;
    localparam logic [THR_W-1:0]    THR_RESET   = 12'd1000;
    localparam logic [MEAN_W-1:0]   MEAN_RESET  = MEAN_W'(2048 << MEAN_SHIFT);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int CMD_DATA_W = HEADER_LEN * 8;

    typedef enum logic [1:0] {
        OP_HDR,
        OP_TRIPLE,
        OP_RAW,
        OP_DROP
    } t_op;

    // OP_HDR: header bytes, byte i at data[8*i +: 8]
    // OP_TRIPLE: sample a in data[11:0], sample c in data[23:12]
    // OP_RAW: byte in data[7:0]
    typedef struct packed {
        t_op                   op;
        logic                  pkt_last;
        logic [CMD_DATA_W-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

@@ rtl/core/aos_front.sv @@
module aos_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_in_byte,
    output logic           o_stall,
    input  aos_pkg::t_q_stat i_q_stat,
    output logic           o_push,
    output aos_pkg::t_cmd  o_cmd
);
    import aos_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic             r_pkt_ok;
    logic [1:0]       r_phase;
    logic [7:0]       r_hdr [HEADER_LEN];
    logic [7:0]       r_t0;
    logic [7:0]       r_t1;

    logic                  acc;
    logic                  is_hdr;
    logic                  hdr_end;
    logic                  pkt_end;
    logic                  in_triples;
    logic                  hdr_ok;
    logic [15:0]           len;
    logic [CMD_DATA_W-1:0] hdr_vec;
    logic                  gen;
    t_cmd                  cmd;
    logic [SAMPLE_W-1:0]   samp_a;
    logic [SAMPLE_W-1:0]   samp_c;

    assign o_stall    = i_q_stat.full;
    assign acc        = i_valid && !i_q_stat.full;
    assign is_hdr     = r_pos < POS_W'(HEADER_LEN);
    assign hdr_end    = r_pos == POS_W'(HEADER_LEN - 1);
    assign pkt_end    = r_pos == POS_W'(PACKET_TOTAL - 1);
    assign in_triples = r_pos < POS_W'(HEADER_LEN + FULL_TRIPLE_BYTES);
    assign len        = {r_hdr[5], r_hdr[4]};
    assign hdr_ok     = (r_hdr[0] == SYNC_FIRST) && (r_hdr[1] == SYNC_SECOND) &&
                        (len == 16'(PAYLOAD_LEN));
    assign samp_a     = {r_t1[3:0], r_t0};
    assign samp_c     = {i_in_byte, r_t1[7:4]};

    always_comb begin
        for (int i = 0; i < HEADER_LEN - 1; i++) begin
            hdr_vec[8*i +: 8] = r_hdr[i];
        end
        hdr_vec[8*(HEADER_LEN-1) +: 8] = i_in_byte;
    end

    // classify the byte into a command for the back end
    always_comb begin
        gen          = 1'b0;
        cmd.op       = OP_RAW;
        cmd.pkt_last = pkt_end;
        cmd.data     = '0;
        if (is_hdr) begin
            if (hdr_end && hdr_ok) begin
                gen      = 1'b1;
                cmd.op   = OP_HDR;
                cmd.data = hdr_vec;
            end
        end else if (!r_pkt_ok) begin
            if (pkt_end) begin
                gen    = 1'b1;
                cmd.op = OP_DROP;
            end
        end else if (in_triples) begin
            if (r_phase == 2'd2) begin
                gen                        = 1'b1;
                cmd.op                     = OP_TRIPLE;
                cmd.data[SAMPLE_W-1:0]     = samp_a;
                cmd.data[2*SAMPLE_W-1:SAMPLE_W] = samp_c;
            end
        end else begin
            gen           = 1'b1;
            cmd.op        = OP_RAW;
            cmd.data[7:0] = i_in_byte;
        end
    end

    assign o_push = acc && gen;
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_pkt_ok <= 1'b0;
            r_phase  <= '0;
        end else if (acc) begin
            if (pkt_end) begin
                r_pos    <= '0;
                r_pkt_ok <= 1'b0;
            end else begin
                r_pos <= r_pos + POS_W'(1);
            end
            if (hdr_end) begin
                r_pkt_ok <= hdr_ok;
                r_phase  <= '0;
            end else if (!is_hdr && r_pkt_ok && in_triples) begin
                r_phase <= (r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;
            end
        end
        if (acc && is_hdr) begin
            r_hdr[r_pos[HDR_IDX_W-1:0]] <= i_in_byte;
        end
        if (acc && !is_hdr && r_pkt_ok && in_triples) begin
            if (r_phase == 2'd0) begin
                r_t0 <= i_in_byte;
            end
            if (r_phase == 2'd1) begin
                r_t1 <= i_in_byte;
            end
        end
    end

endmodule

@@ rtl/core/aos_fifo.sv @@
module aos_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  aos_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output aos_pkg::t_cmd    o_cmd,
    output aos_pkg::t_q_stat o_stat
);
    import aos_pkg::*;

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    assign o_stat.empty = r_count == '0;
    assign o_stat.full  = r_count == FIFO_CNT_W'(FIFO_DEPTH);
    assign o_cmd        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + FIFO_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - FIFO_CNT_W'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

@@ rtl/core/aos_back.sv @@
module aos_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic [aos_pkg::THR_W-1:0] i_cfg_data,
    input  aos_pkg::t_q_stat          i_q_stat,
    input  aos_pkg::t_cmd             i_cmd,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [7:0]                o_out_byte,
    output logic                      o_run_last,
    output logic                      o_packet_last,
    output logic                      o_dropped
);
    import aos_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FA,
        S_FC,
        S_EMIT,
        S_HDR,
        S_ONE
    } t_state;

    t_state               r_state,     n_state;
    t_cmd                 r_cmd,       n_cmd;
    logic [HDR_IDX_W-1:0] r_cnt,       n_cnt;
    logic [THR_W-1:0]     r_thr,       n_thr;
    logic [MEAN_W-1:0]    r_mean,      n_mean;
    logic [SAMPLE_W-1:0]  r_prev,      n_prev;
    logic [SAMPLE_W-1:0]  r_fa,        n_fa;
    logic [SAMPLE_W-1:0]  r_fc,        n_fc;
    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_out_byte,  n_out_byte;
    logic                 r_run_last,  n_run_last;
    logic                 r_pkt_last,  n_pkt_last;
    logic                 r_dropped,   n_dropped;

    logic                slot_free;
    logic [SAMPLE_W-1:0] samp;
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] diff;
    logic                outlier;
    logic [SAMPLE_W-1:0] cur;
    logic [SAMPLE_W:0]   pair_sum;
    logic [SAMPLE_W-1:0] avg;
    logic [MEAN_W-1:0]   mean_upd;
    logic [7:0]          tri_byte;

    assign slot_free = !r_out_valid || !i_stall;

    // outlier rejection and two-tap average, one sample per cycle
    assign samp     = (r_state == S_FA) ? r_cmd.data[SAMPLE_W-1:0]
                                        : r_cmd.data[2*SAMPLE_W-1:SAMPLE_W];
    assign mean     = r_mean[MEAN_SHIFT +: SAMPLE_W];
    assign diff     = (samp > mean) ? samp - mean : mean - samp;
    assign outlier  = diff > r_thr;
    assign cur      = outlier ? mean : samp;
    assign pair_sum = {1'b0, r_prev} + {1'b0, cur};
    assign avg      = pair_sum[SAMPLE_W:1];
    assign mean_upd = r_mean + MEAN_W'(samp) - MEAN_W'(mean);

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    tri_byte = r_fa[7:0];
            2'd1:    tri_byte = {r_fc[3:0], r_fa[11:8]};
            default: tri_byte = r_fc[11:4];
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_cnt       = r_cnt;
        n_thr       = r_thr;
        n_mean      = r_mean;
        n_prev      = r_prev;
        n_fa        = r_fa;
        n_fc        = r_fc;
        n_out_valid = r_out_valid && i_stall;
        n_out_byte  = r_out_byte;
        n_run_last  = r_run_last;
        n_pkt_last  = r_pkt_last;
        n_dropped   = r_dropped;
        o_pop       = 1'b0;

        if (i_cfg_valid) begin
            n_thr = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_cnt = '0;
                    case (i_cmd.op)
                        OP_HDR:    n_state = S_HDR;
                        OP_TRIPLE: n_state = S_FA;
                        OP_RAW:    n_state = S_ONE;
                        OP_DROP:   n_state = S_ONE;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_FA, S_FC: begin
                if (!outlier) begin
                    n_mean = mean_upd;
                end
                n_prev = cur;
                if (r_state == S_FA) begin
                    n_fa    = avg;
                    n_state = S_FC;
                end else begin
                    n_fc    = avg;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = tri_byte;
                    n_dropped   = 1'b0;
                    n_run_last  = r_cnt == HDR_IDX_W'(2);
                    n_pkt_last  = (r_cnt == HDR_IDX_W'(2)) && r_cmd.pkt_last;
                    n_cnt       = r_cnt + HDR_IDX_W'(1);
                    if (r_cnt == HDR_IDX_W'(2)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_HDR: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_cmd.data[8*r_cnt +: 8];
                    n_dropped   = 1'b0;
                    n_pkt_last  = 1'b0;
                    n_run_last  = r_cnt == HDR_IDX_W'(HEADER_LEN - 1);
                    n_cnt       = r_cnt + HDR_IDX_W'(1);
                    if (r_cnt == HDR_IDX_W'(HEADER_LEN - 1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ONE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_run_last  = 1'b1;
                    if (r_cmd.op == OP_DROP) begin
                        n_out_byte = 8'd0;
                        n_pkt_last = 1'b0;
                        n_dropped  = 1'b1;
                    end else begin
                        n_out_byte = r_cmd.data[7:0];
                        n_pkt_last = r_cmd.pkt_last;
                        n_dropped  = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= THR_RESET;
            r_mean      <= MEAN_RESET;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_thr       <= n_thr;
            r_mean      <= n_mean;
            r_prev      <= n_prev;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_cnt      <= n_cnt;
        r_fa       <= n_fa;
        r_fc       <= n_fc;
        r_out_byte <= n_out_byte;
        r_run_last <= n_run_last;
        r_pkt_last <= n_pkt_last;
        r_dropped  <= n_dropped;
    end

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_run_last    = r_run_last;
    assign o_packet_last = r_pkt_last;
    assign o_dropped     = r_dropped;

`ifndef NO_ASSERTIONS
    a_pkt_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_packet_last) |-> o_run_last)
        else $error("packet end not on last item of its input byte");
    a_drop_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dropped) |-> (o_out_byte == 8'd0 && o_run_last && !o_packet_last))
        else $error("malformed drop marker");
`endif

endmodule

@@ rtl/core/audio_packet_outlier_smoother_unit.sv @@
// Flow: a header goes through the command queue, the S_HDR state and the output register;
// a payload triple goes through the queue, the S_FA, S_FC and S_EMIT states and the output register.
// Throughput: one input byte per cycle while the 4-entry command queue has room;
// the back-end sequencer pops a new command only after it has loaded every output
// byte of the last one, bounded by its one output register.
// Reset: synchronous, active low; threshold 1000, mean 2048 << MEAN_SHIFT.
module audio_packet_outlier_smoother_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_in_byte,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [7:0]                o_out_byte,
    output logic                      o_run_last,
    output logic                      o_packet_last,
    output logic                      o_dropped,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [aos_pkg::THR_W-1:0] i_cfg_data
);
    import aos_pkg::*;

    t_q_stat q_stat;
    t_cmd    push_cmd;
    t_cmd    head_cmd;
    logic    push;
    logic    pop;

    assign o_cfg_ready = 1'b1;

    aos_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_in_byte (i_in_byte),
        .o_stall   (o_stall),
        .i_q_stat  (q_stat),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    aos_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    aos_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_q_stat      (q_stat),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_packet_last (o_packet_last),
        .o_dropped     (o_dropped)
    );

endmodule
